[hw/rtl/isotonic_regression_pava_top_macros.svh]
// assertion macros for the isotonic regression block
`ifndef ISOTONIC_REGRESSION_PAVA_TOP_MACROS_SVH
`define ISOTONIC_REGRESSION_PAVA_TOP_MACROS_SVH

// same-cycle implication
`define IRP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IRP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/irp_pkg.sv]
// shared types and constants for the isotonic regression block
package irp_pkg;

  localparam int COUNT_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int FIT_W      = FRAC_BITS + 1;
  localparam int IDX_W      = 10;
  localparam int DIV_CNT_W  = $clog2(FRAC_BITS);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P1_CHK,
    ST_P1_PUSH,
    ST_P1_MUL,
    ST_P1_CMP,
    ST_P1_STK,
    ST_FL_T2,
    ST_FL_T1,
    ST_FL_END,
    ST_P2_RDA,
    ST_P2_RDB,
    ST_P2_INIT,
    ST_P2_DIV,
    ST_P2_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic read;
    logic fit_init;
    logic rd_cum;
    logic push;
    logic mul;
    logic pop;
    logic t2_load;
    logic next_pt;
    logic fl_t2;
    logic fl_t1;
    logic fl_end;
    logic rd_a;
    logic rd_b;
    logic div_init;
    logic div_step;
    logic wr_fit;
    logic k_inc;
    logic set_done;
  } cmd_t;

  typedef struct packed {
    logic i_end;
    logic top_zero;
    logic top_ge1;
    logic top_ge2;
    logic top_ge3;
    logic greater;
    logic div_last;
    logic wr_last;
    logic k_last;
  } sts_t;

endpackage

[hw/rtl/irp_ctrl.sv]
// controller state machine for loads, reads, the pooling pass and the fit pass
module irp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          action_i,
  input  logic          last_i,
  input  irp_pkg::sts_t sts_i,
  output irp_pkg::cmd_t cmd_o,
  output logic          busy_o
);

  irp_pkg::state_e state_q, state_d;
  logic            acc;

  assign acc    = start_i && (state_q == irp_pkg::ST_IDLE);
  assign busy_o = (state_q != irp_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= irp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      irp_pkg::ST_IDLE: begin
        if (acc && !action_i && last_i) state_d = irp_pkg::ST_P1_CHK;
      end
      irp_pkg::ST_P1_CHK: begin
        state_d = sts_i.i_end ? irp_pkg::ST_FL_T2 : irp_pkg::ST_P1_PUSH;
      end
      irp_pkg::ST_P1_PUSH: begin
        state_d = sts_i.top_ge1 ? irp_pkg::ST_P1_MUL : irp_pkg::ST_P1_CHK;
      end
      irp_pkg::ST_P1_MUL: state_d = irp_pkg::ST_P1_CMP;
      irp_pkg::ST_P1_CMP: begin
        if (sts_i.greater && sts_i.top_ge3) state_d = irp_pkg::ST_P1_STK;
        else state_d = irp_pkg::ST_P1_CHK;
      end
      irp_pkg::ST_P1_STK: state_d = irp_pkg::ST_P1_MUL;
      irp_pkg::ST_FL_T2:  state_d = irp_pkg::ST_FL_T1;
      irp_pkg::ST_FL_T1:  state_d = irp_pkg::ST_FL_END;
      irp_pkg::ST_FL_END: begin
        state_d = sts_i.top_zero ? irp_pkg::ST_DONE : irp_pkg::ST_P2_RDA;
      end
      irp_pkg::ST_P2_RDA:  state_d = irp_pkg::ST_P2_RDB;
      irp_pkg::ST_P2_RDB:  state_d = irp_pkg::ST_P2_INIT;
      irp_pkg::ST_P2_INIT: state_d = irp_pkg::ST_P2_DIV;
      irp_pkg::ST_P2_DIV: begin
        if (sts_i.div_last) state_d = irp_pkg::ST_P2_WR;
      end
      irp_pkg::ST_P2_WR: begin
        if (sts_i.wr_last) begin
          state_d = sts_i.k_last ? irp_pkg::ST_DONE : irp_pkg::ST_P2_RDA;
        end
      end
      irp_pkg::ST_DONE: state_d = irp_pkg::ST_IDLE;
      default:          state_d = irp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      irp_pkg::ST_IDLE: begin
        cmd_o.load     = acc && !action_i;
        cmd_o.read     = acc && action_i;
        cmd_o.fit_init = acc && !action_i && last_i;
      end
      irp_pkg::ST_P1_CHK: cmd_o.rd_cum = !sts_i.i_end;
      irp_pkg::ST_P1_PUSH: begin
        cmd_o.push    = 1'b1;
        cmd_o.next_pt = !sts_i.top_ge1;
      end
      irp_pkg::ST_P1_MUL: cmd_o.mul = 1'b1;
      irp_pkg::ST_P1_CMP: begin
        cmd_o.pop     = sts_i.greater;
        cmd_o.next_pt = !(sts_i.greater && sts_i.top_ge3);
      end
      irp_pkg::ST_P1_STK:  cmd_o.t2_load  = 1'b1;
      irp_pkg::ST_FL_T2:   cmd_o.fl_t2    = 1'b1;
      irp_pkg::ST_FL_T1:   cmd_o.fl_t1    = 1'b1;
      irp_pkg::ST_FL_END:  cmd_o.fl_end   = 1'b1;
      irp_pkg::ST_P2_RDA:  cmd_o.rd_a     = 1'b1;
      irp_pkg::ST_P2_RDB:  cmd_o.rd_b     = 1'b1;
      irp_pkg::ST_P2_INIT: cmd_o.div_init = 1'b1;
      irp_pkg::ST_P2_DIV:  cmd_o.div_step = 1'b1;
      irp_pkg::ST_P2_WR: begin
        cmd_o.wr_fit = 1'b1;
        cmd_o.k_inc  = sts_i.wr_last;
      end
      irp_pkg::ST_DONE: cmd_o.set_done = 1'b1;
      default: cmd_o = '0;
    endcase
  end

endmodule

[hw/rtl/irp_dpath.sv]
// datapath: point store, block stack, cross-multiply compare, divider, fit store
module irp_dpath #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  irp_pkg::cmd_t                       cmd_i,
  output irp_pkg::sts_t                       sts_o,
  input  logic [irp_pkg::COUNT_BITS-1:0]      successes_i,
  input  logic [irp_pkg::COUNT_BITS-1:0]      trials_i,
  input  logic [irp_pkg::IDX_W-1:0]           index_i,
  output logic [irp_pkg::FIT_W-1:0]           fitted_value_o,
  output logic                                in_range_o,
  output logic                                valid_o
);

  localparam int AW     = $clog2(MAX_POINTS);
  localparam int CNT_W  = AW + 1;
  localparam int CW     = irp_pkg::COUNT_BITS + AW;
  localparam int SDEPTH = MAX_POINTS + 1;
  localparam int SAW    = $clog2(SDEPTH);
  localparam int XW     = AW + irp_pkg::IDX_W;

  typedef struct packed {
    logic [CNT_W-1:0] start;
    logic [CW-1:0]    s;
    logic [CW-1:0]    w;
  } blk_t;

  // load side
  logic [CNT_W-1:0] count_q;
  logic             done_q;
  logic [CW-1:0]    tot_s_q, tot_w_q;
  logic [CNT_W-1:0] eff_cnt;
  logic [CW-1:0]    base_s, base_w, new_s, new_w;
  logic [irp_pkg::COUNT_BITS-1:0] s_sat;
  logic             store;

  logic [2*CW-1:0]  cum_mem [MAX_POINTS];
  logic [2*CW-1:0]  cum_rd_q;
  logic [CW-1:0]    cur_s, cur_w;

  // pooling pass
  logic [CNT_W-1:0] i_q;
  logic [CW-1:0]    prev_s_q, prev_w_q;
  logic [SAW-1:0]   top_q, k_q;
  blk_t             t1_q, t2_q;
  blk_t             stk_mem [SDEPTH];
  blk_t             stk_rd_q;
  logic             stk_we, stk_re;
  logic [SAW-1:0]   stk_wa, stk_ra;
  blk_t             stk_wd;
  logic [2*CW-1:0]  prod_a_q, prod_b_q;
  logic [CW-1:0]    sa, wa, sb, wb;

  // fit pass
  blk_t             cur_q;
  logic [CNT_W-1:0] nxt_start_q, wi_q;
  logic [CW:0]      div_r_q, div_r2;
  logic [CW-1:0]    div_d_q, num, den;
  logic [irp_pkg::FRAC_BITS-1:0] div_q_q;
  logic             sat_q;
  logic [irp_pkg::DIV_CNT_W-1:0] dcnt_q;
  logic [irp_pkg::FIT_W-1:0] fit_val;
  logic [irp_pkg::FIT_W-1:0] fit_mem [MAX_POINTS];
  logic [irp_pkg::FIT_W-1:0] fit_rd_q;

  // read side
  logic [XW-1:0]    idx_ext;
  logic             hit, val_q, rng_q;

  assign eff_cnt = done_q ? '0 : count_q;
  assign base_s  = (eff_cnt == '0) ? '0 : tot_s_q;
  assign base_w  = (eff_cnt == '0) ? '0 : tot_w_q;
  assign s_sat   = (successes_i > trials_i) ? trials_i : successes_i;
  assign new_s   = base_s + CW'(s_sat);
  assign new_w   = base_w + CW'(trials_i);
  assign store   = cmd_i.load && (trials_i != '0) && (eff_cnt < CNT_W'(MAX_POINTS));

  assign cur_s = cum_rd_q[2*CW-1:CW];
  assign cur_w = cum_rd_q[CW-1:0];

  assign sa = t1_q.s - t2_q.s;
  assign wa = t1_q.w - t2_q.w;
  assign sb = cur_s - t1_q.s;
  assign wb = cur_w - t1_q.w;

  assign num = stk_rd_q.s - cur_q.s;
  assign den = stk_rd_q.w - cur_q.w;
  assign div_r2 = {div_r_q[CW-1:0], 1'b0};
  assign fit_val = sat_q ? irp_pkg::FIT_W'(1) << irp_pkg::FRAC_BITS
                         : {1'b0, div_q_q};

  assign idx_ext = {{AW{1'b0}}, index_i};
  assign hit     = done_q && (idx_ext < XW'(count_q));

  // stack ports
  always_comb begin
    stk_we = 1'b0;
    stk_wa = top_q - SAW'(2);
    stk_wd = t2_q;
    if ((cmd_i.push || cmd_i.fl_t2) && sts_o.top_ge2) begin
      stk_we = 1'b1;
    end else if (cmd_i.fl_t1 && sts_o.top_ge1) begin
      stk_we = 1'b1;
      stk_wa = top_q - SAW'(1);
      stk_wd = t1_q;
    end else if (cmd_i.fl_end) begin
      stk_we = 1'b1;
      stk_wa = top_q;
      stk_wd = '{start: count_q, s: prev_s_q, w: prev_w_q};
    end
  end

  always_comb begin
    stk_re = 1'b0;
    stk_ra = k_q;
    if (cmd_i.pop && sts_o.top_ge3) begin
      stk_re = 1'b1;
      stk_ra = top_q - SAW'(3);
    end else if (cmd_i.rd_a) begin
      stk_re = 1'b1;
    end else if (cmd_i.rd_b) begin
      stk_re = 1'b1;
      stk_ra = k_q + SAW'(1);
    end
  end

  always_comb begin
    sts_o          = '0;
    sts_o.i_end    = (i_q == count_q);
    sts_o.top_zero = (top_q == '0);
    sts_o.top_ge1  = (top_q >= SAW'(1));
    sts_o.top_ge2  = (top_q >= SAW'(2));
    sts_o.top_ge3  = (top_q >= SAW'(3));
    sts_o.greater  = (prod_a_q > prod_b_q);
    sts_o.div_last = (dcnt_q == irp_pkg::DIV_CNT_W'(irp_pkg::FRAC_BITS - 1));
    sts_o.wr_last  = ((wi_q + CNT_W'(1)) == nxt_start_q);
    sts_o.k_last   = ((k_q + SAW'(1)) == top_q);
  end

  // control counters and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
      i_q     <= '0;
      top_q   <= '0;
      k_q     <= '0;
      dcnt_q  <= '0;
      val_q   <= 1'b0;
      rng_q   <= 1'b0;
    end else begin
      val_q <= cmd_i.read;
      if (cmd_i.read) rng_q <= hit;
      if (cmd_i.load) begin
        count_q <= store ? eff_cnt + CNT_W'(1) : eff_cnt;
        done_q  <= 1'b0;
      end
      if (cmd_i.set_done) done_q <= 1'b1;
      if (cmd_i.fit_init) begin
        i_q   <= '0;
        top_q <= '0;
      end else if (cmd_i.push) begin
        top_q <= top_q + SAW'(1);
      end else if (cmd_i.pop) begin
        top_q <= top_q - SAW'(1);
      end
      if (cmd_i.next_pt) i_q <= i_q + CNT_W'(1);
      if (cmd_i.fl_end) k_q <= '0;
      else if (cmd_i.k_inc) k_q <= k_q + SAW'(1);
      if (cmd_i.div_init) dcnt_q <= '0;
      else if (cmd_i.div_step) dcnt_q <= dcnt_q + irp_pkg::DIV_CNT_W'(1);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (store) begin
      tot_s_q <= new_s;
      tot_w_q <= new_w;
    end
    if (cmd_i.fit_init) begin
      prev_s_q <= '0;
      prev_w_q <= '0;
    end else if (cmd_i.next_pt) begin
      prev_s_q <= cur_s;
      prev_w_q <= cur_w;
    end
    if (cmd_i.push) begin
      t2_q <= t1_q;
      t1_q <= '{start: i_q, s: prev_s_q, w: prev_w_q};
    end else if (cmd_i.pop) begin
      t1_q <= t2_q;
    end else if (cmd_i.t2_load) begin
      t2_q <= stk_rd_q;
    end
    if (cmd_i.mul) begin
      prod_a_q <= (2*CW)'(sa) * (2*CW)'(wb);
      prod_b_q <= (2*CW)'(sb) * (2*CW)'(wa);
    end
    if (cmd_i.rd_b) cur_q <= stk_rd_q;
    if (cmd_i.div_init) begin
      div_r_q     <= {1'b0, num};
      div_d_q     <= den;
      div_q_q     <= '0;
      sat_q       <= (num >= den);
      nxt_start_q <= stk_rd_q.start;
      wi_q        <= cur_q.start;
    end else if (cmd_i.div_step) begin
      if (div_r2 >= {1'b0, div_d_q}) begin
        div_r_q <= div_r2 - {1'b0, div_d_q};
        div_q_q <= {div_q_q[irp_pkg::FRAC_BITS-2:0], 1'b1};
      end else begin
        div_r_q <= div_r2;
        div_q_q <= {div_q_q[irp_pkg::FRAC_BITS-2:0], 1'b0};
      end
    end else if (cmd_i.wr_fit) begin
      wi_q <= wi_q + CNT_W'(1);
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (store) cum_mem[eff_cnt[AW-1:0]] <= {new_s, new_w};
    if (cmd_i.rd_cum) cum_rd_q <= cum_mem[i_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (stk_re) stk_rd_q <= stk_mem[stk_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_fit) fit_mem[wi_q[AW-1:0]] <= fit_val;
    if (cmd_i.read) fit_rd_q <= fit_mem[idx_ext[AW-1:0]];
  end

  assign valid_o        = val_q;
  assign in_range_o     = rng_q;
  assign fitted_value_o = rng_q ? fit_rd_q : '0;

endmodule

[hw/rtl/isotonic_regression_pava_top.sv]
// top level of the weighted isotonic regression (pool-adjacent-violators) block
// Loads and reads may follow back to back while busy is low.
// A read's result shows on fitted_value_o/in_range_o with valid_o high for exactly one
// cycle, the cycle after the read is accepted; the receiver cannot stall it. A load with
// last set starts the fit and holds busy high: each point passes check and push steps, then
// a multiply and compare once an earlier block exists, and each further block merge adds a
// stack read, multiply and compare (one shared compare unit and one stack read port); the
// block stack is then flushed, each final block is divided bit-serially and written to each of its points, then done.
`include "isotonic_regression_pava_top_macros.svh"

module isotonic_regression_pava_top #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           action_i,
  input  logic [irp_pkg::COUNT_BITS-1:0] successes_i,
  input  logic [irp_pkg::COUNT_BITS-1:0] trials_i,
  input  logic                           last_i,
  input  logic [irp_pkg::IDX_W-1:0]      index_i,
  output logic                           valid_o,
  output logic [irp_pkg::FIT_W-1:0]      fitted_value_o,
  output logic                           in_range_o
);

  irp_pkg::cmd_t cmd;
  irp_pkg::sts_t sts;

  irp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .action_i (action_i),
    .last_i   (last_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  irp_dpath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .successes_i    (successes_i),
    .trials_i       (trials_i),
    .index_i        (index_i),
    .fitted_value_o (fitted_value_o),
    .in_range_o     (in_range_o),
    .valid_o        (valid_o)
  );

  `IRP_ASSERT_NXT(a_read_result, start && !busy && action_i, valid_o, "read gave no result")
  `IRP_ASSERT_IMP(a_no_extra, valid_o, $past(start && !busy && action_i), "stray result")
  `IRP_ASSERT_IMP(a_oor_zero, valid_o && !in_range_o, fitted_value_o == '0, "nonzero miss")
  `IRP_ASSERT_IMP(a_fit_max, valid_o && in_range_o,
                  fitted_value_o <= (irp_pkg::FIT_W'(1) << irp_pkg::FRAC_BITS), "fit above one")

endmodule

[sim/irp_test_pkg.sv]
// item codes shared by the isotonic regression testbench files
package irp_test_pkg;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_READ = 1'b1
  } action_e;

endpackage

[sim/isotonic_regression_pava_checker.sv]
// checker for the isotonic regression block: predicts read results and compares them
`timescale 1ns / 1ps

module isotonic_regression_pava_checker #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  input  logic                           busy,
  input  logic                           action_i,
  input  logic [irp_pkg::COUNT_BITS-1:0] successes_i,
  input  logic [irp_pkg::COUNT_BITS-1:0] trials_i,
  input  logic                           last_i,
  input  logic [irp_pkg::IDX_W-1:0]      index_i,
  input  logic                           valid_o,
  input  logic [irp_pkg::FIT_W-1:0]      fitted_value_o,
  input  logic                           in_range_o,
  output int                             fail_count,
  output int                             pending_reads,
  output int                             load_count,
  output int                             read_count,
  output int                             fit_count,
  output int                             hit_count
);

  typedef struct packed {
    logic [irp_pkg::FIT_W-1:0] value;
    logic                      hit;
  } fit_read_t;

  longint unsigned sum_succ[MAX_POINTS];
  longint unsigned sum_tri[MAX_POINTS];
  logic [irp_pkg::FIT_W-1:0] fit_val[MAX_POINTS];
  int unsigned               block_at[MAX_POINTS];
  int unsigned               n_points;
  bit                        fitted_ok;
  fit_read_t                 expected_reads[$];

  assign pending_reads = expected_reads.size();

  function automatic longint unsigned succ_upto(int unsigned k);
    return (k == 0) ? 64'd0 : sum_succ[k-1];
  endfunction

  function automatic longint unsigned tri_upto(int unsigned k);
    return (k == 0) ? 64'd0 : sum_tri[k-1];
  endfunction

  // pool adjacent violators over the stored cumulative sums
  function automatic void pool_fit();
    int unsigned     depth, a, b, e;
    longint unsigned sa, wa, sb, wb, v;
    depth = 0;
    for (int unsigned i = 0; i < n_points; i++) begin
      block_at[depth++] = i;
      while (depth >= 2) begin
        a  = block_at[depth-2];
        b  = block_at[depth-1];
        sa = succ_upto(b) - succ_upto(a);
        wa = tri_upto(b) - tri_upto(a);
        sb = sum_succ[i] - succ_upto(b);
        wb = sum_tri[i] - tri_upto(b);
        // sums stay below 2^26, so products fit in 64 bits
        if (!(sa * wb > sb * wa)) break;
        depth--;
      end
    end
    for (int unsigned k = 0; k < depth; k++) begin
      a  = block_at[k];
      e  = (k + 1 < depth) ? block_at[k+1] : n_points;
      sa = succ_upto(e) - succ_upto(a);
      wa = tri_upto(e) - tri_upto(a);
      if (sa >= wa) v = 64'd1 << irp_pkg::FRAC_BITS;
      else v = (sa << irp_pkg::FRAC_BITS) / wa;
      for (int unsigned i = a; i < e; i++) fit_val[i] = v[irp_pkg::FIT_W-1:0];
    end
    fitted_ok = 1'b1;
  endfunction

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fit_read_t       want;
    longint unsigned s, t;
    if (!rst_ni) begin
      n_points   = 0;
      fitted_ok  = 1'b0;
      fail_count = 0;
      load_count = 0;
      read_count = 0;
      fit_count  = 0;
      hit_count  = 0;
      expected_reads.delete();
    end else begin
      // results first: a read's result never shows in the cycle it is taken
      if (valid_o) begin
        if (expected_reads.size() == 0) begin
          report("result with no read waiting");
        end else begin
          want = expected_reads.pop_front();
          if (in_range_o !== want.hit)
            report($sformatf("in_range %0b, expected %0b", in_range_o, want.hit));
          if (fitted_value_o !== want.value)
            report($sformatf("fitted_value %0d, expected %0d", fitted_value_o, want.value));
        end
      end
      if (start && !busy) begin
        if (irp_test_pkg::action_e'(action_i) == irp_test_pkg::ACT_READ) begin
          read_count++;
          if (fitted_ok && index_i < n_points) begin
            want.value = fit_val[index_i];
            want.hit   = 1'b1;
            hit_count++;
          end else begin
            want = '0;
          end
          expected_reads.push_back(want);
        end else begin
          load_count++;
          if (fitted_ok) begin
            n_points  = 0;
            fitted_ok = 1'b0;
          end
          t = 64'(trials_i);
          s = (successes_i > trials_i) ? 64'(trials_i) : 64'(successes_i);
          if (t != 0 && n_points < MAX_POINTS) begin
            sum_succ[n_points] = succ_upto(n_points) + s;
            sum_tri[n_points]  = tri_upto(n_points) + t;
            n_points++;
          end
          if (last_i) begin
            pool_fit();
            fit_count++;
          end
        end
      end
    end
  end

endmodule

[sim/isotonic_regression_pava_top_test.sv]
// testbench top for the isotonic regression block: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module isotonic_regression_pava_top_test;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int ITEM_TARGET    = 700;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           start = 1'b0;
  logic                           busy;
  logic                           action_i = irp_test_pkg::ACT_LOAD;
  logic [irp_pkg::COUNT_BITS-1:0] successes_i = '0;
  logic [irp_pkg::COUNT_BITS-1:0] trials_i = '0;
  logic                           last_i = 1'b0;
  logic [irp_pkg::IDX_W-1:0]      index_i = '0;
  logic                           valid_o;
  logic [irp_pkg::FIT_W-1:0]      fitted_value_o;
  logic                           in_range_o;

  int fail_count, pending_reads, load_count, read_count, fit_count, hit_count;
  int items_sent = 0;
  int stall_cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  isotonic_regression_pava_top dut (.*);

  isotonic_regression_pava_checker checker_i (.*);

  // nothing accepted for too long means the block hung
  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item or result for %0d cycles", WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  task automatic send(input irp_test_pkg::action_e act, input logic [15:0] succ,
                      input logic [15:0] tri_n, input logic lst, input logic [9:0] idx);
    @(negedge clk_i);
    // no idling in a quiet stretch of the run
    if (!(items_sent >= 250 && items_sent < 450) && $urandom_range(0, 99) < 15) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    action_i    = act;
    successes_i = succ;
    trials_i    = tri_n;
    last_i      = lst;
    index_i     = idx;
    start       = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic load_pt(input logic [15:0] succ, input logic [15:0] tri_n, input logic lst);
    send(irp_test_pkg::ACT_LOAD, succ, tri_n, lst, 10'($urandom_range(0, 1023)));
  endtask

  task automatic read_at(input logic [9:0] idx);
    send(irp_test_pkg::ACT_READ, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)), idx);
  endtask

  function automatic logic [15:0] rand_trials();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return 16'd0;
    if (pick < 40) return 16'($urandom_range(1, 4));
    if (pick < 70) return 16'($urandom_range(1, 65535));
    return 16'($urandom_range(65000, 65535));
  endfunction

  task automatic random_series(input int unsigned len);
    logic [15:0] t, s;
    for (int unsigned i = 0; i < len; i++) begin
      t = rand_trials();
      if ($urandom_range(0, 99) < 15) s = 16'($urandom);
      else s = 16'($urandom_range(0, t));
      // a stray read after a series' first load is out of range; one before it may hit the last fit
      if ($urandom_range(0, 99) < 3) read_at(10'($urandom_range(0, 1023)));
      load_pt(s, t, i == len - 1);
    end
  endtask

  initial begin
    int unsigned len, waited, room;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reads before any fit, a fit over no points
    read_at(10'd0);
    read_at(10'd1023);
    load_pt(16'd5, 16'd0, 1'b1);
    read_at(10'd0);
    // extremes, saturation, zero trials mid series and with last
    load_pt(16'hffff, 16'hffff, 1'b0);
    load_pt(16'd0, 16'd1, 1'b0);
    load_pt(16'd9, 16'd0, 1'b0);
    load_pt(16'hffff, 16'd3, 1'b0);
    load_pt(16'd1, 16'hffff, 1'b0);
    load_pt(16'd0, 16'hffff, 1'b0);
    load_pt(16'd2, 16'd0, 1'b1);
    for (int i = 0; i < 7; i++) read_at(10'(i));
    read_at(10'd1023);
    // load after a fit starts a new series
    load_pt(16'd1, 16'd3, 1'b1);
    read_at(10'd0);
    read_at(10'd1);

    // one long series
    for (int unsigned i = 0; i < 300; i++)
      load_pt(16'($urandom_range(0, 200)), 16'($urandom_range(1, 400)), i == 299);
    read_at(10'd0);
    read_at(10'd299);
    read_at(10'd300);
    for (int i = 0; i < 4; i++) read_at(10'($urandom_range(0, 1023)));

    while (items_sent < ITEM_TARGET) begin
      len = ($urandom_range(0, 99) < 5) ? $urandom_range(100, 200) : $urandom_range(1, 30);
      room = (items_sent + 10 < ITEM_TARGET) ? ITEM_TARGET - items_sent - 8 : 1;
      if (len > room) len = room;
      random_series(len);
      repeat ($urandom_range(2, 8)) begin
        if ($urandom_range(0, 3) == 0) read_at(10'($urandom_range(0, 1023)));
        else read_at(10'($urandom_range(0, len)));
      end
    end

    @(negedge clk_i);
    start = 1'b0;
    waited = 0;
    while (pending_reads != 0 && waited < 1000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);

    $display("covered %0d loads, %0d reads (%0d in range) over %0d fits", load_count,
             read_count, hit_count, fit_count);
    if (fail_count == 0 && pending_reads == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending_reads);
      $display("status: fail");
    end
    $finish;
  end

endmodule
